[rtl/ssc_pkg.sv]
// shared constants and types for the sorted score table
// operation and status codes, field widths and the cell control bundle
// no dependencies
package ssc_pkg;

    localparam int DEF_CAPACITY = 128;

    localparam int KEY_W   = 16;
    localparam int SCORE_W = 14;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int OUT_W   = 8;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic               capture;
        logic               shift_ins;
        logic               shift_del;
        logic [KEY_W-1:0]   cmp_key;
        logic [SCORE_W-1:0] cmp_score;
        logic [KEY_W-1:0]   new_key;
        logic [SCORE_W-1:0] new_score;
    } t_cell_ctl;

endpackage

[rtl/sorted_score_table.sv]
// Sorted score table: CAPACITY slots held in descending score order.
// Input channel (i_in_valid / o_in_ready) carries mode, key and score;
// output channel (o_out_valid / i_out_ready) carries rank, status, entries.
// Every input transaction yields exactly one output transaction.
// Insert puts the entry behind all equal or higher scores and reports its
// 1-based rank; delete removes the first matching key; find reports the
// rank of the first matching key. A full insert or a missing key is flagged.
// At the accept edge every cell compares its slot against the new key and
// score; in the execute step the match chain runs along the cells, the
// rank is encoded, the cells from the insert or delete point onward shift
// one place in parallel and the result is loaded into the output register.
// A new transaction is accepted only once the last has left execute.
// The next transaction is accepted while a result waits in the output
// register; if that register is still occupied when the next result is
// ready, the block holds in its execute step until the receiver takes it.
// Reset (i_rst_n low, synchronous) empties the table and drops any
// pending result; slot contents are not cleared.
// files: ssc_pkg, ssc_cell
module sorted_score_table
    import ssc_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [SCORE_W-1:0] i_score,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [OUT_W-1:0]   o_rank,
    output logic [STAT_W-1:0]  o_status,
    output logic [OUT_W-1:0]   o_entries
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int WIDE_W = (CNT_W > OUT_W) ? CNT_W : OUT_W;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state              r_state;
    logic [MODE_W-1:0]   r_mode;
    logic [KEY_W-1:0]    r_key;
    logic [SCORE_W-1:0]  r_score;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_rank;
    logic [STAT_W-1:0]   r_status;
    logic [OUT_W-1:0]    n_rank;
    logic [STAT_W-1:0]   n_status;
    logic                w_accept;
    logic                w_fire;
    logic                w_full;
    logic                w_hit;
    logic                w_do_ins;
    logic                w_do_del;
    logic [IDX_W-1:0]    w_pos;
    logic [WIDE_W-1:0]   w_rank_wide;
    logic [WIDE_W-1:0]   w_count_wide;
    t_cell_ctl           w_ctl;

    logic [KEY_W-1:0]    w_key   [CAPACITY];
    logic [SCORE_W-1:0]  w_score [CAPACITY];
    logic [CAPACITY-1:0] w_ge;
    logic [CAPACITY:0]   w_seen;
    logic [CAPACITY-1:0] w_ins_here;
    logic [CAPACITY-1:0] w_first_hit;

    // handshakes
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_fire     = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    assign w_full   = r_count >= CNT_W'(CAPACITY);
    assign w_hit    = w_seen[CAPACITY];
    assign w_do_ins = w_fire && (r_mode == MODE_INSERT) && !w_full;
    assign w_do_del = w_fire && (r_mode == MODE_DELETE) && w_hit;

    // control broadcast to the cells
    always_comb begin
        w_ctl.capture   = w_accept;
        w_ctl.shift_ins = w_do_ins;
        w_ctl.shift_del = w_do_del;
        w_ctl.cmp_key   = i_key;
        w_ctl.cmp_score = i_score;
        w_ctl.new_key   = r_key;
        w_ctl.new_score = r_score;
    end

    assign w_seen[0] = 1'b0;

    // the row of slots
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_W-1:0]   w_lkey;
        logic [SCORE_W-1:0] w_lscore;
        logic               w_lge;
        logic [KEY_W-1:0]   w_rkey;
        logic [SCORE_W-1:0] w_rscore;

        if (g == 0) begin : g_head
            assign w_lkey   = r_key;
            assign w_lscore = r_score;
            assign w_lge    = 1'b1;
        end else begin : g_mid
            assign w_lkey   = w_key[g-1];
            assign w_lscore = w_score[g-1];
            assign w_lge    = w_ge[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_rkey   = '0;
            assign w_rscore = '0;
        end else begin : g_body
            assign w_rkey   = w_key[g+1];
            assign w_rscore = w_score[g+1];
        end

        ssc_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_count       (r_count),
            .i_left_key    (w_lkey),
            .i_left_score  (w_lscore),
            .i_left_ge     (w_lge),
            .i_right_key   (w_rkey),
            .i_right_score (w_rscore),
            .i_seen        (w_seen[g]),
            .o_key         (w_key[g]),
            .o_score       (w_score[g]),
            .o_ge          (w_ge[g]),
            .o_seen        (w_seen[g+1]),
            .o_ins_here    (w_ins_here[g]),
            .o_first_hit   (w_first_hit[g])
        );
    end

    // encode the one-hot position of the insert slot or the first hit
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if ((r_mode == MODE_INSERT) ? w_ins_here[i] : w_first_hit[i]) begin
                w_pos = w_pos | IDX_W'(i);
            end
        end
    end

    assign w_rank_wide = WIDE_W'(w_pos) + WIDE_W'(1);

    // result and new count for the transaction in execution
    always_comb begin
        n_rank   = '0;
        n_status = ST_DONE;
        n_count  = r_count;
        unique case (r_mode)
            MODE_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_rank  = w_rank_wide[OUT_W-1:0];
                    n_count = r_count + CNT_W'(1);
                end
            end
            MODE_DELETE: begin
                if (w_hit) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_status = ST_MISSING;
                end
            end
            MODE_FIND: begin
                if (w_hit) begin
                    n_rank = w_rank_wide[OUT_W-1:0];
                end else begin
                    n_status = ST_MISSING;
                end
            end
            default: begin
                n_rank = '0;
            end
        endcase
    end

    assign w_count_wide = WIDE_W'(n_count);

    // sequencer, table count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready && !w_fire) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_fire) begin
                        r_state     <= S_IDLE;
                        r_count     <= n_count;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // transaction payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode  <= i_mode;
            r_key   <= i_key;
            r_score <= i_score;
        end
        if (w_fire) begin
            r_rank    <= n_rank;
            r_status  <= n_status;
            o_entries <= w_count_wide[OUT_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rank      = r_rank;
    assign o_status    = r_status;

endmodule

[rtl/ssc_cell.sv]
// one table slot: holds a key and score, compares them on capture
// and shifts toward either neighbor on insert or delete; uses ssc_pkg
module ssc_cell
    import ssc_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  logic [CNT_W-1:0]   i_count,
    input  logic [KEY_W-1:0]   i_left_key,
    input  logic [SCORE_W-1:0] i_left_score,
    input  logic               i_left_ge,
    input  logic [KEY_W-1:0]   i_right_key,
    input  logic [SCORE_W-1:0] i_right_score,
    input  logic               i_seen,
    output logic [KEY_W-1:0]   o_key,
    output logic [SCORE_W-1:0] o_score,
    output logic               o_ge,
    output logic               o_seen,
    output logic               o_ins_here,
    output logic               o_first_hit
);

    logic [KEY_W-1:0]   r_key;
    logic [SCORE_W-1:0] r_score;
    logic               r_ge;
    logic               r_match;
    logic               w_held;

    // slot holds a live entry when its index is below the count
    assign w_held = i_count > CNT_W'(IDX);

    // compare flags, taken when a transaction is accepted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ge    <= 1'b0;
            r_match <= 1'b0;
        end else if (i_ctl.capture) begin
            r_ge    <= w_held && (r_score >= i_ctl.cmp_score);
            r_match <= w_held && (r_key == i_ctl.cmp_key);
        end
    end

    // slot contents: open a gap for insert, close one for delete
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_ins && !r_ge) begin
            if (i_left_ge) begin
                r_key   <= i_ctl.new_key;
                r_score <= i_ctl.new_score;
            end else begin
                r_key   <= i_left_key;
                r_score <= i_left_score;
            end
        end else if (i_ctl.shift_del && (i_seen || r_match)) begin
            r_key   <= i_right_key;
            r_score <= i_right_score;
        end
    end

    // match chain toward the tail and one-hot position flags
    assign o_seen      = i_seen | r_match;
    assign o_first_hit = r_match & ~i_seen;
    assign o_ins_here  = i_left_ge & ~r_ge;
    assign o_ge        = r_ge;
    assign o_key       = r_key;
    assign o_score     = r_score;

endmodule

[rtl/ssc_checker.sv]
// port-level checks for the sorted score table, bound to the top level
// uses ssc_pkg status codes; attaches to sorted_score_table
module ssc_checker
    import ssc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [OUT_W-1:0]   o_rank,
    input logic [STAT_W-1:0]  o_status,
    input logic [OUT_W-1:0]   o_entries
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

    // an accepted transaction occupies the execute step next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted during execute step");

    // flagged results carry no rank
    a_rank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_DONE) |-> (o_rank == '0))
        else $error("rank set on flagged result");

    // status code is always a defined one
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_DONE || o_status == ST_MISSING
                         || o_status == ST_FULL))
        else $error("undefined status code");

endmodule

bind sorted_score_table ssc_checker u_ssc_checker (.*);

[sim/tb_top.sv]
`timescale 1ns / 100ps
// self-checking bench for the sorted score table: insert, delete, find and no-op transactions
// every reply is checked against a behavioral copy of the table kept in the bench
// depends on ssc_pkg and sorted_score_table
module tb_top;
    import ssc_pkg::*;

    localparam int TABLE_DEPTH  = DEF_CAPACITY;
    localparam int RANDOM_OPS   = 1200;
    localparam int QUIET_TAIL   = 150;
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int POOL_SIZE    = 48;

    // mode 3 has no operation behind it
    localparam logic [MODE_W-1:0]  MODE_NOP  = 2'd3;
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
    localparam logic [KEY_W-1:0]   KEY_MAX   = '1;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [KEY_W-1:0]   key;
        logic [SCORE_W-1:0] score;
    } t_table_op;

    typedef struct packed {
        logic [OUT_W-1:0]  rank;
        logic [STAT_W-1:0] status;
        logic [OUT_W-1:0]  entries;
    } t_table_reply;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic [MODE_W-1:0]  i_mode      = '0;
    logic [KEY_W-1:0]   i_key       = '0;
    logic [SCORE_W-1:0] i_score     = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [OUT_W-1:0]   o_rank;
    logic [STAT_W-1:0]  o_status;
    logic [OUT_W-1:0]   o_entries;

    // behavioral copy of the table
    logic [KEY_W-1:0]   tbl_keys   [TABLE_DEPTH];
    logic [SCORE_W-1:0] tbl_scores [TABLE_DEPTH];
    int                 tbl_count = 0;

    t_table_op        op_backlog[$];
    t_table_reply     awaited_replies[$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    t_table_op    drive_op;
    t_table_op    taken_op;
    t_table_reply got_reply;
    t_table_reply want_reply;

    int mismatch_count = 0;
    int accepted_ops   = 0;
    int reply_count    = 0;
    int cycle_count    = 0;
    int send_idle      = 0;
    int recv_stall     = 0;
    bit in_taken       = 1'b0;
    bit hold_off       = 1'b0;

    sorted_score_table #(
        .CAPACITY(TABLE_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_key       (i_key),
        .i_score     (i_score),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_rank      (o_rank),
        .o_status    (o_status),
        .o_entries   (o_entries)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // first slot holding key, or the count when the key is absent
    function automatic int find_key_slot(logic [KEY_W-1:0] key);
        int slot;
        slot = 0;
        while (slot < tbl_count && tbl_keys[slot] != key)
            slot++;
        return slot;
    endfunction

    // apply one transaction to the table copy and return the reply it must give
    function automatic t_table_reply table_update(t_table_op op);
        t_table_reply reply;
        int           slot;
        int           idx;
        reply.rank   = '0;
        reply.status = ST_DONE;
        case (op.mode)
            MODE_INSERT: begin
                if (tbl_count >= TABLE_DEPTH) begin
                    reply.status = ST_FULL;
                end else begin
                    // new entry goes behind every equal or higher score
                    slot = 0;
                    while (slot < tbl_count && tbl_scores[slot] >= op.score)
                        slot++;
                    for (idx = tbl_count; idx > slot; idx--) begin
                        tbl_keys[idx]   = tbl_keys[idx-1];
                        tbl_scores[idx] = tbl_scores[idx-1];
                    end
                    tbl_keys[slot]   = op.key;
                    tbl_scores[slot] = op.score;
                    tbl_count++;
                    reply.rank = OUT_W'(slot + 1);
                end
            end
            MODE_DELETE: begin
                slot = find_key_slot(op.key);
                if (slot >= tbl_count) begin
                    reply.status = ST_MISSING;
                end else begin
                    for (idx = slot; idx + 1 < tbl_count; idx++) begin
                        tbl_keys[idx]   = tbl_keys[idx+1];
                        tbl_scores[idx] = tbl_scores[idx+1];
                    end
                    tbl_count--;
                end
            end
            MODE_FIND: begin
                slot = find_key_slot(op.key);
                if (slot >= tbl_count)
                    reply.status = ST_MISSING;
                else
                    reply.rank = OUT_W'(slot + 1);
            end
            default: ;
        endcase
        reply.entries = OUT_W'(tbl_count);
        return reply;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // idle bursts stop in the tail and in one window out of every four
    function automatic bit idle_allowed();
        return op_backlog.size() >= QUIET_TAIL && (accepted_ops / 100) % 4 != 3;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return KEY_W'($urandom);
    endfunction

    // many small scores for ties, the rest spread up to the field maximum
    function automatic logic [SCORE_W-1:0] pick_score();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            return SCORE_W'($urandom_range(0, 7));
        if (roll < 75)
            return SCORE_W'($urandom_range(0, 10000));
        if (roll < 90)
            return SCORE_W'($urandom_range(10001, 16383));
        if (roll < 95)
            return '0;
        return SCORE_MAX;
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode(int ins_pct, int del_pct, int find_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < ins_pct)
            return MODE_INSERT;
        if (roll < ins_pct + del_pct)
            return MODE_DELETE;
        if (roll < ins_pct + del_pct + find_pct)
            return MODE_FIND;
        return MODE_NOP;
    endfunction

    task automatic push_op(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                           logic [SCORE_W-1:0] score);
        t_table_op op;
        op.mode  = mode;
        op.key   = key;
        op.score = score;
        op_backlog.push_back(op);
    endtask

    // sender: holds each transaction until accepted, idles in short bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (send_idle > 0) begin
                send_idle--;
                i_in_valid <= 1'b0;
            end else if (op_backlog.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
                send_idle = $urandom_range(0, 3);
                i_in_valid <= 1'b0;
            end else begin
                drive_op = op_backlog.pop_front();
                i_in_valid <= 1'b1;
                i_mode     <= drive_op.mode;
                i_key      <= drive_op.key;
                i_score    <= drive_op.score;
            end
        end
    end

    // receiver: random stall bursts, plus the long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            i_out_ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            i_out_ready <= 1'b0;
        end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
            recv_stall = $urandom_range(0, 3);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // long receiver hold-off so the block fills up and stalls its input
    initial begin
        int held;
        while (accepted_ops < HOLD_AFTER)
            @(posedge i_clk);
        hold_off = 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++)
            @(posedge i_clk);
        hold_off = 1'b0;
    end

    // monitor: check replies, then predict for the newly accepted transaction
    always @(posedge i_clk) begin
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got_reply.rank    = o_rank;
                got_reply.status  = o_status;
                got_reply.entries = o_entries;
                if (awaited_replies.size() == 0) begin
                    report_mismatch($sformatf("reply %0d arrived with nothing awaited",
                                              reply_count));
                end else begin
                    want_reply = awaited_replies.pop_front();
                    if (got_reply.rank !== want_reply.rank)
                        report_mismatch($sformatf("reply %0d rank %0d, want %0d",
                                                  reply_count, got_reply.rank,
                                                  want_reply.rank));
                    if (got_reply.status !== want_reply.status)
                        report_mismatch($sformatf("reply %0d status %0d, want %0d",
                                                  reply_count, got_reply.status,
                                                  want_reply.status));
                    if (got_reply.entries !== want_reply.entries)
                        report_mismatch($sformatf("reply %0d entries %0d, want %0d",
                                                  reply_count, got_reply.entries,
                                                  want_reply.entries));
                end
                reply_count++;
            end
            if (i_in_valid && o_in_ready) begin
                taken_op.mode  = i_mode;
                taken_op.key   = i_key;
                taken_op.score = i_score;
                awaited_replies.push_back(table_update(taken_op));
                in_taken = 1'b1;
                accepted_ops++;
            end
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int gen;
        int phase;
        int idx;
        for (idx = 0; idx < POOL_SIZE; idx++)
            key_pool[idx] = KEY_W'($urandom);
        key_pool[0] = '0;
        key_pool[1] = KEY_MAX;

        // directed: empty table, extremes, ties, duplicates, head and tail removal
        push_op(MODE_FIND,   16'h1234, '0);
        push_op(MODE_DELETE, 16'h1234, '0);
        push_op(MODE_NOP,    16'h0000, '0);
        push_op(MODE_INSERT, 16'h0000, '0);
        push_op(MODE_INSERT, KEY_MAX,  SCORE_MAX);
        push_op(MODE_INSERT, 16'h1234, 14'd10000);
        push_op(MODE_INSERT, 16'h1234, 14'd10000);
        push_op(MODE_INSERT, 16'hAAAA, '0);
        push_op(MODE_INSERT, 16'h5555, 14'd10001);
        push_op(MODE_FIND,   16'h1234, '0);
        push_op(MODE_FIND,   16'hAAAA, '0);
        push_op(MODE_FIND,   16'hBEEF, SCORE_MAX);
        push_op(MODE_DELETE, KEY_MAX,  '0);
        push_op(MODE_FIND,   16'h5555, '0);
        push_op(MODE_DELETE, 16'h1234, '0);
        push_op(MODE_FIND,   16'h1234, '0);
        push_op(MODE_DELETE, 16'h7777, '0);
        push_op(MODE_NOP,    KEY_MAX,  SCORE_MAX);
        push_op(MODE_DELETE, 16'hAAAA, '0);
        push_op(MODE_FIND,   16'hAAAA, '0);
        push_op(MODE_DELETE, 16'h1234, '0);
        push_op(MODE_DELETE, 16'h5555, '0);
        push_op(MODE_DELETE, 16'h0000, '0);
        push_op(MODE_DELETE, 16'h0000, '0);

        // random: fill to full, churn while full, then drain, repeated
        for (gen = 0; gen < RANDOM_OPS; gen++) begin
            phase = (gen / 100) % 5;
            case (phase)
                0, 1:    push_op(pick_mode(90, 5, 4), pick_key(), pick_score());
                2:       push_op(pick_mode(45, 20, 30), pick_key(), pick_score());
                default: push_op(pick_mode(15, 65, 17), pick_key(), pick_score());
            endcase
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (op_backlog.size() != 0 || i_in_valid || awaited_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (awaited_replies.size() != 0)
            report_mismatch($sformatf("%0d replies never arrived", awaited_replies.size()));

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
